[hdl/stmf_pkg.sv]
package stmf_pkg;

   // history ring and window geometry
   localparam int HISTORY_DEPTH = 14;
   localparam int WINDOW_SIZE   = 12;
   localparam int SAMPLE_BITS   = 12;
   localparam int WARMUP_LEN    = HISTORY_DEPTH - 1;

   localparam int SLOT_BITS = $clog2(HISTORY_DEPTH);
   localparam int WARM_BITS = $clog2(HISTORY_DEPTH);
   localparam int CNT_BITS  = $clog2(WINDOW_SIZE);

   // at most eight kept values are summed
   localparam int SUM_BITS  = SAMPLE_BITS + 3;

   // divide by three through a reciprocal, exact below 2**DIV3_BITS
   localparam int DIV3_BITS  = SAMPLE_BITS + 2;
   localparam int DIV3_SHIFT = DIV3_BITS + 1;
   localparam int PROD_BITS  = DIV3_BITS + DIV3_SHIFT - 1;
   localparam logic [DIV3_SHIFT-2:0] DIV3_MULT =
      (DIV3_SHIFT-1)'(((1 << DIV3_SHIFT) + 2) / 3);

   // trim mode codes
   localparam logic [1:0] TRIM_EIGHT = 2'd1;
   localparam logic [1:0] TRIM_FOUR  = 2'd3;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [WINDOW_SIZE-1:0] window_type;

   typedef struct packed {
      logic clear;
      logic insert;
   } sort_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SUM,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

[hdl/stmf_sort.sv]
module stmf_sort
   import stmf_pkg::*;
(
   input  logic         clock,
   input  sort_ctl_type ctl,
   input  sample_type   value,
   output window_type   sorted
);

   window_type                 sorted_ff;
   window_type                 sorted_in;
   logic [WINDOW_SIZE-1:0]     le;

   // each lane keeps, takes the new value, or takes its lower neighbor
   always_comb begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         le[k] = (sorted_ff[k] <= value);
      end
      sorted_in[0] = le[0] ? sorted_ff[0] : value;
      for (int k = 1; k < WINDOW_SIZE; k++) begin
         if (le[k]) begin
            sorted_in[k] = sorted_ff[k];
         end else if (le[k-1]) begin
            sorted_in[k] = value;
         end else begin
            sorted_in[k] = sorted_ff[k-1];
         end
      end
   end

   // empty lanes hold the largest code and drop off the top end
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         sorted_ff <= '1;
      end else if (ctl.insert) begin
         sorted_ff <= sorted_in;
      end
   end

   assign sorted = sorted_ff;

endmodule

[hdl/sliding_trimmed_mean_filter.sv]
// Sliding trimmed mean filter over a ring of recent converter samples.
// Input channel req_: one 12-bit sample per beat, taken when req_valid is
// high and req_stall is low. Result channel rsp_: one beat per sample with
// the trimmed mean and a ready flag, taken when rsp_valid is high and
// rsp_stall is low. Configuration channel csr_: a write of the 2-bit trim
// mode, taken when csr_valid and csr_ready are high; write only while idle.
// The first 13 samples fill the ring and give a zero result with the ready
// flag low; that result skips the sort and goes from acceptance straight
// to the emit state. After warm-up a sample passes from acceptance to the
// result register through twelve reads of the ring memory (one port, one
// read a cycle, the first one at the slot of the new sample) feeding an
// insertion sorter, then a drain step, a sum of the kept lanes, a divide
// and the load of the result register. One sample is in work at a
// time; the next is taken on the cycle after the result is loaded.
// A stalled result stays in the output register while the block takes
// and works on the next sample; that one waits until the register frees.
// Reset clears the ring contents to zero (through per-slot valid bits),
// the write slot, the warm-up count and the trim mode.
module sliding_trimmed_mean_filter
   import stmf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_filtered,
   output logic                   rsp_ready_res,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_data
);

   state_type state_ff, state_in;

   logic [1:0]             trim_mode_ff;
   logic [SLOT_BITS-1:0]   write_slot_ff;
   logic [WARM_BITS-1:0]   warmup_ff;
   logic [SLOT_BITS-1:0]   rd_ptr_ff;
   logic [CNT_BITS-1:0]    rd_cnt_ff;
   logic                   rd_vld_ff;
   logic                   rd_hit_ff;
   sample_type             rd_data_ff;
   logic [HISTORY_DEPTH-1:0] slot_vld_ff;
   sample_type             history_mem [HISTORY_DEPTH];

   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   sample_type             mean_ff, mean_in;
   logic                   res_ready_ff;
   logic                   rsp_valid_ff;
   sample_type             rsp_filtered_ff;
   logic                   rsp_ready_res_ff;

   logic                   req_take;
   logic                   in_warmup;
   logic                   mem_write;
   logic                   rsp_free;
   logic                   rsp_load;
   logic                   read_last;
   sort_ctl_type           sort_ctl;
   window_type             sorted;
   sample_type             sort_value;
   logic [DIV3_BITS-1:0]   half_sum;
   logic [PROD_BITS-1:0]   div3_prod;

   // handshake terms
   assign req_take  = req_valid && !req_stall;
   assign in_warmup = (warmup_ff < WARM_BITS'(WARMUP_LEN));
   assign mem_write = req_take && (in_warmup || (req_sample != '0));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign read_last = (rd_cnt_ff == CNT_BITS'(WINDOW_SIZE - 1));
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = in_warmup ? ST_EMIT : ST_READ;
            end
         end
         ST_READ: begin
            if (read_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SUM;
         ST_SUM:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall       = 1'b1;
      sort_ctl.clear  = 1'b0;
      sort_ctl.insert = 1'b0;
      rsp_load        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            sort_ctl.clear = 1'b1;
         end
         ST_READ:  sort_ctl.insert = rd_vld_ff;
         ST_DRAIN: sort_ctl.insert = rd_vld_ff;
         ST_SUM:   ;
         ST_DIV:   ;
         ST_EMIT:  rsp_load = rsp_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // trim mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         trim_mode_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         trim_mode_ff <= csr_data;
      end
   end

   // write slot and warm-up count
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         warmup_ff     <= '0;
      end else if (req_take) begin
         if (write_slot_ff == SLOT_BITS'(HISTORY_DEPTH - 1)) begin
            write_slot_ff <= '0;
         end else begin
            write_slot_ff <= write_slot_ff + 1'b1;
         end
         if (in_warmup) begin
            warmup_ff <= warmup_ff + 1'b1;
         end
      end
   end

   // ring memory, written at acceptance except for zero samples after warm-up, read one slot a cycle
   always_ff @(posedge clock) begin
      if (mem_write) begin
         history_mem[write_slot_ff] <= req_sample;
      end
      rd_data_ff <= history_mem[rd_ptr_ff];
   end

   // slot valid bits stand in for the all-zero reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (mem_write) begin
            slot_vld_ff[write_slot_ff] <= 1'b1;
         end
         rd_vld_ff <= (state_ff == ST_READ);
      end
   end

   // read pointer walks back from the newest slot with wrap
   always_ff @(posedge clock) begin
      rd_hit_ff <= slot_vld_ff[rd_ptr_ff];
      if (req_take) begin
         rd_ptr_ff <= write_slot_ff;
         rd_cnt_ff <= '0;
      end else if (state_ff == ST_READ) begin
         rd_cnt_ff <= rd_cnt_ff + 1'b1;
         if (rd_ptr_ff == '0) begin
            rd_ptr_ff <= SLOT_BITS'(HISTORY_DEPTH - 1);
         end else begin
            rd_ptr_ff <= rd_ptr_ff - 1'b1;
         end
      end
   end

   assign sort_value = rd_hit_ff ? rd_data_ff : '0;

   stmf_sort u_sort (
      .clock  (clock),
      .ctl    (sort_ctl),
      .value  (sort_value),
      .sorted (sorted)
   );

   // sum of the kept middle lanes
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         if (trim_mode_ff == TRIM_EIGHT) begin
            if (k >= 2 && k <= 9) begin
               sum_in = sum_in + SUM_BITS'(sorted[k]);
            end
         end else if (trim_mode_ff == TRIM_FOUR) begin
            if (k >= 4 && k <= 7) begin
               sum_in = sum_in + SUM_BITS'(sorted[k]);
            end
         end else begin
            if (k >= 3 && k <= 8) begin
               sum_in = sum_in + SUM_BITS'(sorted[k]);
            end
         end
      end
   end

   // floor mean: shifts for eight and four, halve then reciprocal for six
   assign half_sum  = sum_ff[SUM_BITS-1:1];
   assign div3_prod = PROD_BITS'(half_sum) * PROD_BITS'(DIV3_MULT);

   always_comb begin
      priority if (trim_mode_ff == TRIM_EIGHT) begin
         mean_in = sum_ff[SAMPLE_BITS+2:3];
      end else if (trim_mode_ff == TRIM_FOUR) begin
         mean_in = sum_ff[SAMPLE_BITS+1:2];
      end else begin
         mean_in = div3_prod[DIV3_SHIFT +: SAMPLE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (req_take) begin
         mean_ff      <= '0;
         res_ready_ff <= !in_warmup;
      end else if (state_ff == ST_DIV) begin
         mean_ff <= mean_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff  <= mean_ff;
         rsp_ready_res_ff <= res_ready_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_ready_res = rsp_ready_res_ff;

   // checks
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      write_slot_ff < SLOT_BITS'(HISTORY_DEPTH))
      else $error("write slot out of range");

   a_warm_sat: assert property (@(posedge clock) disable iff (reset)
      warmup_ff <= WARM_BITS'(WARMUP_LEN))
      else $error("warm-up count past its limit");

   a_warm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready_res |-> rsp_filtered == '0)
      else $error("nonzero result during warm-up");

   a_insert_state: assert property (@(posedge clock) disable iff (reset)
      sort_ctl.insert |-> (state_ff == ST_READ || state_ff == ST_DRAIN))
      else $error("sorter insert outside the read phase");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> state_ff == ST_IDLE)
      else $error("result loaded without returning to idle");

endmodule
